### hdl/et_pkg.sv
// et_pkg: shared constants, types and state encodings for the totient block.
// No dependencies; used by every module under hdl/.
package et_pkg;

  localparam int VALUE_BITS  = 32;
  localparam int PRIME_LIMIT = 65536;
  localparam int STORE_DEPTH = 6542;
  localparam int PRIME_W     = 16;
  localparam int IDX_W       = $clog2(STORE_DEPTH + 1);
  localparam int CAND_W      = $clog2(PRIME_LIMIT + 1);
  localparam int COMP_AW     = $clog2(PRIME_LIMIT);
  localparam int DIV_STEPS   = VALUE_BITS;
  localparam int STEP_W      = $clog2(DIV_STEPS);

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic                  trivial;
  } item_t;

  typedef struct packed {
    logic               en;
    logic [IDX_W-1:0]   addr;
    logic [PRIME_W-1:0] data;
  } store_wr_t;

  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] count;
  } sieve_stat_t;

  typedef enum logic [2:0] {
    SV_CLEAR,
    SV_READ,
    SV_CHECK,
    SV_MARK,
    SV_DONE
  } sieve_state_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_RD,
    B_SQ,
    B_CMP,
    B_DIV,
    B_DEC,
    B_FAC,
    B_MUL,
    B_FIN,
    B_FMUL,
    B_OUT
  } back_state_t;

endpackage

### hdl/et_sieve.sv
// et_sieve: after reset clears a composite bitmap, then sieves it and
// streams every prime found into the prime store write port. Uses et_pkg.
module et_sieve (
  input  logic               clk,
  input  logic               rst,
  output et_pkg::store_wr_t  store_wr,
  output et_pkg::sieve_stat_t stat
);

  logic composite [et_pkg::PRIME_LIMIT];
  logic comp_rd;
  logic comp_we;
  logic [et_pkg::COMP_AW-1:0] comp_wa;
  logic comp_wd;

  et_pkg::sieve_state_t state, state_next;
  logic [et_pkg::CAND_W-1:0] addr, addr_next;
  logic [et_pkg::CAND_W-1:0] cand, cand_next;
  logic [et_pkg::CAND_W-1:0] mult, mult_next;
  logic [et_pkg::IDX_W-1:0]  count, count_next;
  logic [2*et_pkg::CAND_W-1:0] cand_sq;
  logic [et_pkg::CAND_W:0] mult_sum;

  always_ff @(posedge clk) begin
    if (comp_we) composite[comp_wa] <= comp_wd;
    comp_rd <= composite[cand[et_pkg::COMP_AW-1:0]];
  end

  assign cand_sq  = cand * cand;
  assign mult_sum = {1'b0, mult} + {1'b0, cand};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= et_pkg::SV_CLEAR;
      addr  <= '0;
      cand  <= '0;
      mult  <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      addr  <= addr_next;
      cand  <= cand_next;
      mult  <= mult_next;
      count <= count_next;
    end
  end

  always_comb begin
    state_next = state;
    addr_next  = addr;
    cand_next  = cand;
    mult_next  = mult;
    count_next = count;
    comp_we    = 1'b0;
    comp_wa    = addr[et_pkg::COMP_AW-1:0];
    comp_wd    = 1'b0;
    store_wr   = '0;
    unique case (state)
      et_pkg::SV_CLEAR: begin
        comp_we   = 1'b1;
        addr_next = addr + 1'b1;
        if (addr == et_pkg::CAND_W'(et_pkg::PRIME_LIMIT - 1)) begin
          cand_next  = et_pkg::CAND_W'(2);
          state_next = et_pkg::SV_READ;
        end
      end
      et_pkg::SV_READ: begin
        // bitmap read of cand is issued this cycle
        if (cand == et_pkg::CAND_W'(et_pkg::PRIME_LIMIT)) state_next = et_pkg::SV_DONE;
        else state_next = et_pkg::SV_CHECK;
      end
      et_pkg::SV_CHECK: begin
        if (!comp_rd) begin
          if (count < et_pkg::IDX_W'(et_pkg::STORE_DEPTH)) begin
            store_wr.en   = 1'b1;
            store_wr.addr = count;
            store_wr.data = cand[et_pkg::PRIME_W-1:0];
            count_next    = count + 1'b1;
          end
          if (cand_sq < (2*et_pkg::CAND_W)'(et_pkg::PRIME_LIMIT)) begin
            mult_next  = cand_sq[et_pkg::CAND_W-1:0];
            state_next = et_pkg::SV_MARK;
          end else begin
            cand_next  = cand + 1'b1;
            state_next = et_pkg::SV_READ;
          end
        end else begin
          cand_next  = cand + 1'b1;
          state_next = et_pkg::SV_READ;
        end
      end
      et_pkg::SV_MARK: begin
        comp_we   = 1'b1;
        comp_wa   = mult[et_pkg::COMP_AW-1:0];
        comp_wd   = 1'b1;
        mult_next = mult_sum[et_pkg::CAND_W-1:0];
        if (mult_sum >= (et_pkg::CAND_W+1)'(et_pkg::PRIME_LIMIT)) begin
          cand_next  = cand + 1'b1;
          state_next = et_pkg::SV_READ;
        end
      end
      et_pkg::SV_DONE: ;
      default: state_next = et_pkg::SV_CLEAR;
    endcase
  end

  assign stat.done  = (state == et_pkg::SV_DONE);
  assign stat.count = count;

endmodule

### hdl/et_front.sv
// et_front: input channel, trivial-value classification and a two-entry
// queue toward the back end. Uses et_pkg.
module et_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [et_pkg::VALUE_BITS-1:0] value,
  output logic                          q_valid,
  output et_pkg::item_t                 q_item,
  input  logic                          q_pop
);

  et_pkg::item_t slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] fill;
  logic       push;

  assign in_ready = (fill != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (fill != 2'd0);
  assign q_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr].value   <= value;
      slots[wr_ptr].trivial <= (value <= et_pkg::VALUE_BITS'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

### hdl/et_back.sv
// et_back: prime store memory, shared bit-serial divider and the
// factoring sequencer with the output register. Uses et_pkg.
module et_back (
  input  logic                          clk,
  input  logic                          rst,
  input  et_pkg::store_wr_t             store_wr,
  input  et_pkg::sieve_stat_t           stat,
  input  logic                          q_valid,
  input  et_pkg::item_t                 q_item,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [et_pkg::VALUE_BITS-1:0] totient
);

  localparam int VB = et_pkg::VALUE_BITS;
  localparam int PW = et_pkg::PRIME_W;

  logic [PW-1:0] prime_store [et_pkg::STORE_DEPTH];
  logic [PW-1:0] rd_data;

  et_pkg::back_state_t state, state_next;
  logic [et_pkg::IDX_W-1:0] idx, idx_next;
  logic [VB-1:0] v, v_next, rem, rem_next, ans, ans_next;
  logic [VB-1:0] pk, pk_next, pkprev, pkprev_next, fac, fac_next;
  logic [PW-1:0] p, p_next;
  logic [2*PW-1:0] psq, psq_next;
  logic seen, seen_next;
  logic [PW-1:0] dr, dr_next;
  logic [VB-1:0] dq, dq_next;
  logic [et_pkg::STEP_W-1:0] step, step_next;
  logic [PW:0] trial;
  logic [VB+PW-1:0] pk_prod;
  logic [2*VB-1:0] ans_prod;
  logic load_out;

  always_ff @(posedge clk) begin
    if (store_wr.en) prime_store[store_wr.addr] <= store_wr.data;
    rd_data <= prime_store[idx];
  end

  assign trial    = {dr, dq[VB-1]};
  assign pk_prod  = pk * p;
  assign ans_prod = ans * fac;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= et_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
    idx    <= idx_next;
    v      <= v_next;
    rem    <= rem_next;
    ans    <= ans_next;
    pk     <= pk_next;
    pkprev <= pkprev_next;
    fac    <= fac_next;
    p      <= p_next;
    psq    <= psq_next;
    seen   <= seen_next;
    dr     <= dr_next;
    dq     <= dq_next;
    step   <= step_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (load_out) totient <= ans;
  end

  always_comb begin
    state_next  = state;
    idx_next    = idx;
    v_next      = v;
    rem_next    = rem;
    ans_next    = ans;
    pk_next     = pk;
    pkprev_next = pkprev;
    fac_next    = fac;
    p_next      = p;
    psq_next    = psq;
    seen_next   = seen;
    dr_next     = dr;
    dq_next     = dq;
    step_next   = step;
    q_pop       = 1'b0;
    load_out    = 1'b0;
    unique case (state)
      et_pkg::B_IDLE: begin
        if (stat.done && q_valid) begin
          q_pop    = 1'b1;
          v_next   = q_item.value;
          rem_next = q_item.value;
          idx_next = '0;
          if (q_item.trivial) begin
            ans_next   = '0;
            state_next = et_pkg::B_OUT;
          end else begin
            ans_next   = VB'(1);
            state_next = et_pkg::B_RD;
          end
        end
      end
      et_pkg::B_RD: begin
        if (idx == stat.count) state_next = et_pkg::B_FIN;
        else state_next = et_pkg::B_SQ;
      end
      et_pkg::B_SQ: begin
        p_next     = rd_data;
        psq_next   = rd_data * rd_data;
        state_next = et_pkg::B_CMP;
      end
      et_pkg::B_CMP: begin
        if (p < PW'(2) || psq > v) begin
          state_next = et_pkg::B_FIN;
        end else begin
          pk_next    = VB'(1);
          pkprev_next = VB'(1);
          seen_next  = 1'b0;
          dr_next    = '0;
          dq_next    = rem;
          step_next  = '0;
          state_next = et_pkg::B_DIV;
        end
      end
      et_pkg::B_DIV: begin
        // restoring division, one quotient bit per cycle
        if (trial >= {1'b0, p}) begin
          dr_next = PW'(trial - {1'b0, p});
          dq_next = {dq[VB-2:0], 1'b1};
        end else begin
          dr_next = trial[PW-1:0];
          dq_next = {dq[VB-2:0], 1'b0};
        end
        step_next = step + 1'b1;
        if (step == et_pkg::STEP_W'(et_pkg::DIV_STEPS - 1)) state_next = et_pkg::B_DEC;
      end
      et_pkg::B_DEC: begin
        if (dr == '0) begin
          rem_next    = dq;
          pkprev_next = pk;
          pk_next     = pk_prod[VB-1:0];
          seen_next   = 1'b1;
          step_next   = '0;
          state_next  = et_pkg::B_DIV;
        end else if (seen) begin
          state_next = et_pkg::B_FAC;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = et_pkg::B_RD;
        end
      end
      et_pkg::B_FAC: begin
        fac_next   = pk - pkprev;
        state_next = et_pkg::B_MUL;
      end
      et_pkg::B_MUL: begin
        ans_next   = ans_prod[VB-1:0];
        idx_next   = idx + 1'b1;
        state_next = et_pkg::B_RD;
      end
      et_pkg::B_FIN: begin
        // leftover cofactor is prime
        if (rem > VB'(1)) begin
          fac_next   = rem - 1'b1;
          state_next = et_pkg::B_FMUL;
        end else begin
          state_next = et_pkg::B_OUT;
        end
      end
      et_pkg::B_FMUL: begin
        ans_next   = ans_prod[VB-1:0];
        state_next = et_pkg::B_OUT;
      end
      et_pkg::B_OUT: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = et_pkg::B_IDLE;
        end
      end
      default: state_next = et_pkg::B_IDLE;
    endcase
  end

  a_busy_after_sieve: assert property (@(posedge clk) disable iff (rst)
    (state != et_pkg::B_IDLE) |-> stat.done)
    else $error("back end busy before prime table filled");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == et_pkg::B_DIV) |-> (p >= PW'(2)))
    else $error("division by a prime below two");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (state == et_pkg::B_OUT && out_valid && !out_ready) |=> (state == et_pkg::B_OUT))
    else $error("result dropped while output beat stalled");

endmodule

### hdl/euler_totient.sv
// euler_totient: Euler totient by trial division over a sieved prime table.
// Processing time per value grows with each prime tried and with each extra division by a
// found factor, since every trial division runs through the bit-serial divider.
// One value in the back end at a time; the front queue holds two more beats.
// After reset the sieve clears and scans a 65536-bit map before the first value
// is worked; values are queued meanwhile.
module euler_totient (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [et_pkg::VALUE_BITS-1:0] value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [et_pkg::VALUE_BITS-1:0] totient
);

  et_pkg::store_wr_t   store_wr;
  et_pkg::sieve_stat_t stat;
  et_pkg::item_t       q_item;
  logic                q_valid;
  logic                q_pop;

  et_sieve u_sieve (
    .clk      (clk),
    .rst      (rst),
    .store_wr (store_wr),
    .stat     (stat)
  );

  et_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .value    (value),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  et_back u_back (
    .clk       (clk),
    .rst       (rst),
    .store_wr  (store_wr),
    .stat      (stat),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .totient   (totient)
  );

endmodule

### verif/euler_totient_tb.sv
// euler_totient_tb: self-checking bench for the trial-division totient block.
// Depends on hdl/et_pkg.sv and hdl/euler_totient.sv; directed table, then random values.
module euler_totient_tb;

  localparam int LIMIT_CYCLES = 100_000_000;
  localparam int N_RANDOM     = 100;

  typedef struct {
    logic [et_pkg::VALUE_BITS-1:0] value;
    bit                            typed;
    logic [et_pkg::VALUE_BITS-1:0] totient;
  } vec_t;

  logic                          clk;
  logic                          rst;
  logic                          in_valid;
  logic                          in_ready;
  logic [et_pkg::VALUE_BITS-1:0] value;
  logic                          out_valid;
  logic                          out_ready;
  logic [et_pkg::VALUE_BITS-1:0] totient;

  logic [et_pkg::VALUE_BITS-1:0] pending_totients[$];
  bit                            is_composite[et_pkg::PRIME_LIMIT];
  int unsigned                   primes[$];
  int                            errors = 0;
  int                            results_seen = 0;
  int                            cycle_count = 0;
  int                            stall_left = 0;

  euler_totient dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .value(value),
    .out_valid(out_valid), .out_ready(out_ready), .totient(totient)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               pending_totients.size());
      $display("FAILURE");
      $finish;
    end
  end

  task automatic build_primes();
    int unsigned i;
    int unsigned j;
    for (i = 2; i < et_pkg::PRIME_LIMIT; i++) begin
      if (!is_composite[i]) begin
        if (primes.size() < et_pkg::STORE_DEPTH) primes.insert(primes.size(), i);
        for (j = i * i; j < et_pkg::PRIME_LIMIT; j += i) is_composite[j] = 1'b1;
      end
    end
  endtask

  // trial division stops once p*p passes the original value, not the remainder
  function automatic logic [et_pkg::VALUE_BITS-1:0] totient_of(
      logic [et_pkg::VALUE_BITS-1:0] v);
    longint unsigned n;
    longint unsigned rem;
    longint unsigned acc;
    longint unsigned p;
    longint unsigned pk;
    n = v;
    rem = n;
    acc = 1;
    if (n <= 1) return '0;
    foreach (primes[i]) begin
      p = primes[i];
      if (p * p > n) break;
      if (rem % p == 0) begin
        pk = 1;
        while (rem % p == 0) begin
          rem = rem / p;
          pk = pk * p;
        end
        acc = acc * (pk - pk / p);
      end
    end
    if (rem > 1) acc = acc * (rem - 1);
    return acc[et_pkg::VALUE_BITS-1:0];
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(9) == 0) return $urandom_range(40, 5);
    return $urandom_range(2);
  endfunction

  task automatic report_mismatch(string what, logic [et_pkg::VALUE_BITS-1:0] got,
                                 logic [et_pkg::VALUE_BITS-1:0] want);
    $display("mismatch %s: got %0d want %0d (cycle %0d)", what, got, want, cycle_count);
    errors++;
  endtask

  task automatic send_value(logic [et_pkg::VALUE_BITS-1:0] v, bit typed,
                            logic [et_pkg::VALUE_BITS-1:0] want);
    int gap;
    gap = pick_gap();
    repeat (gap) @(negedge clk);
    value = v;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_totients.insert(pending_totients.size(), typed ? want : totient_of(v));
    @(negedge clk);
    in_valid = 1'b0;
    value = $urandom();
  endtask

  // sink side: random stalls, a few of them long, checked at the rising edge
  always @(negedge clk) begin
    if (rst) begin
      out_ready = 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready = 1'b0;
    end else if ($urandom_range(49) == 0) begin
      stall_left = $urandom_range(60, 10);
      out_ready = 1'b0;
    end else begin
      out_ready = ($urandom_range(3) != 0);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_totients.size() == 0)
        report_mismatch("unexpected beat", totient, '0);
      else if (totient !== pending_totients[0])
        report_mismatch("totient", totient, pending_totients.pop_front());
      else
        void'(pending_totients.pop_front());
    end
  end

  vec_t directed[$];

  initial begin
    logic [et_pkg::VALUE_BITS-1:0] v;
    int sel;
    rst = 1'b1;
    in_valid = 1'b0;
    value = '0;
    build_primes();

    directed.insert(directed.size(), '{32'd0, 1, 32'd0});
    directed.insert(directed.size(), '{32'd1, 1, 32'd0});
    directed.insert(directed.size(), '{32'd2, 1, 32'd1});
    directed.insert(directed.size(), '{32'd3, 1, 32'd2});
    directed.insert(directed.size(), '{32'd4, 1, 32'd2});
    directed.insert(directed.size(), '{32'd6, 0, 32'd0});
    directed.insert(directed.size(), '{32'd36, 0, 32'd0});
    directed.insert(directed.size(), '{32'd97, 1, 32'd96});
    directed.insert(directed.size(), '{32'd65536, 1, 32'd32768});
    directed.insert(directed.size(), '{32'd65521, 1, 32'd65520});
    directed.insert(directed.size(), '{32'd65537, 1, 32'd65536});
    directed.insert(directed.size(), '{32'd1000000, 0, 32'd0});
    directed.insert(directed.size(), '{32'h8000_0000, 1, 32'h4000_0000});
    directed.insert(directed.size(), '{32'd4294967291, 1, 32'd4294967290});
    directed.insert(directed.size(), '{32'hFFFF_FFFF, 0, 32'd0});

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed[i]) send_value(directed[i].value, directed[i].typed, directed[i].totient);

    // large values walk thousands of primes, so most random values stay small
    for (int k = 0; k < N_RANDOM; k++) begin
      sel = $urandom_range(19);
      if (sel < 12)      v = $urandom_range(65535);
      else if (sel < 18) v = $urandom() & 32'h000F_FFFF;
      else if (sel < 19) v = 32'd1 << $urandom_range(31);
      else               v = $urandom() & 32'h003F_FFFF;
      send_value(v, 0, '0);
    end

    while (pending_totients.size() != 0) begin
      @(posedge clk);
    end
    repeat (300) @(posedge clk);

    $display("covered %0d directed and %0d random values, %0d results checked",
             directed.size(), N_RANDOM, results_seen);
    $display("including zero, one, powers of two, large primes and all-ones input");
    if (errors == 0 && pending_totients.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### files.f
hdl/et_pkg.sv
hdl/et_sieve.sv
hdl/et_front.sv
hdl/et_back.sv
hdl/euler_totient.sv
verif/euler_totient_tb.sv
